FILE: hdl/tjik_pkg.sv
// ----------------------------------------------------------------------------
// tjik_pkg
// Shared types, codes and constants of the three-joint arm solver.
// ----------------------------------------------------------------------------
package tjik_pkg;

    // opcodes and result status
    localparam logic       OP_SOLVE    = 1'b0;
    localparam logic       OP_CLEAR    = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNREACH  = 2'd1;
    localparam logic [1:0] ST_LIMIT    = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 4;
    localparam logic [3:0] REG_HEIGHT     = 4'd0;
    localparam logic [3:0] REG_REACH      = 4'd1;
    localparam logic [3:0] REG_UPPER      = 4'd2;
    localparam logic [3:0] REG_LOWER      = 4'd3;
    localparam logic [3:0] REG_SHLD_MIN   = 4'd4;
    localparam logic [3:0] REG_SHLD_MAX   = 4'd5;
    localparam logic [3:0] REG_ELBW_MIN   = 4'd6;
    localparam logic [3:0] REG_ELBW_MAX   = 4'd7;

    // fixed point constants
    localparam logic signed [17:0] PI_HALF_Q13 = 18'sd12868;
    localparam logic signed [31:0] PI_HALF_Q28 = 32'sd421657428;
    localparam logic [31:0]        ONE_SQ_Q28  = 32'h1000_0000;
    localparam int                 SQRT_STEPS  = 16;
    localparam int                 DIV_STEPS   = 15;
    localparam int                 ANG_IDX_W   = 5;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_MTY, S_RSQ, S_RSQW, S_MAX, S_MPZ, S_ML1, S_ML2,
        S_MLL, S_DEN, S_CMP, S_DIVW, S_MCC, S_SSQ, S_SSQW, S_MK1, S_MK2,
        S_MK3, S_A1W, S_A2, S_A2W, S_A3, S_A3W, S_A4, S_A4W, S_LIM, S_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        COR_IDLE, COR_NORM, COR_ROT, COR_FIN
    } cor_phase_t;

    // atan(2^-i) in Q.28
    function automatic logic signed [31:0] atan_tab(input logic [ANG_IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            default: v = 32'sd32;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/tjik_mul.sv
// ----------------------------------------------------------------------------
// tjik_mul
// Shared signed 18x18 multiplier with a registered product.
// ----------------------------------------------------------------------------
module tjik_mul
    import tjik_pkg::*;
(
    input  logic                clk,
    input  logic signed [17:0]  a,
    input  logic signed [17:0]  b,
    output logic signed [35:0]  prod
);

    logic signed [35:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/tjik_isqrt.sv
// ----------------------------------------------------------------------------
// tjik_isqrt
// Bit-pair integer square root of a 32-bit value, one step per cycle.
// ----------------------------------------------------------------------------
module tjik_isqrt
    import tjik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] operand,
    output logic        done,
    output logic [15:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] v_reg;
    logic [31:0] r_reg;
    logic [31:0] b_reg;
    logic [32:0] trial;

    assign trial = {1'b0, r_reg} + {1'b0, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= operand;
            r_reg <= '0;
            b_reg <= 32'h4000_0000;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg <= v_reg - trial[31:0];
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[15:0];

endmodule

FILE: hdl/tjik_div.sv
// ----------------------------------------------------------------------------
// tjik_div
// Restoring divider for the elbow cosine, num * 2^14 / den with num <= den.
// ----------------------------------------------------------------------------
module tjik_div
    import tjik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [14:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [31:0] den_reg;
    logic [14:0] quot_reg;
    logic        qbit;
    logic [33:0] rem_sub;

    assign qbit    = rem_reg >= {2'b00, den_reg};
    assign rem_sub = qbit ? (rem_reg - {2'b00, den_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {2'b00, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= {rem_sub[32:0], 1'b0};
            quot_reg <= {quot_reg[13:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: hdl/tjik_cordic.sv
// ----------------------------------------------------------------------------
// tjik_cordic
// Vectoring CORDIC atan2 with input normalization, result in Q3.13.
// ----------------------------------------------------------------------------
module tjik_cordic
    import tjik_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] y_in,
    input  logic signed [31:0] x_in,
    output logic               done,
    output logic signed [15:0] angle
);

    localparam logic signed [33:0] LIM27 = 34'sd134217728;
    localparam logic signed [33:0] LIM30 = 34'sd1073741824;

    cor_phase_t phase_reg;
    cor_phase_t phase_next;

    logic signed [33:0]     x_reg;
    logic signed [33:0]     y_reg;
    logic signed [31:0]     z_reg;
    logic [ANG_IDX_W-1:0]   i_reg;
    logic                   done_reg;
    logic signed [15:0]     angle_reg;

    logic                   small4;
    logic                   small1;
    logic                   last_step;
    logic signed [33:0]     dx;
    logic signed [33:0]     dy;
    logic signed [31:0]     ang;
    logic signed [31:0]     z_round;

    // doubling four times is exact while both stay under 2^27
    assign small4 = (x_reg < LIM27) && (x_reg > -LIM27)
                 && (y_reg < LIM27) && (y_reg > -LIM27);
    assign small1 = (x_reg < LIM30) && (x_reg > -LIM30)
                 && (y_reg < LIM30) && (y_reg > -LIM30);
    assign last_step = i_reg == ANG_IDX_W'(ITERATIONS - 1);
    assign dx      = y_reg >>> i_reg;
    assign dy      = x_reg >>> i_reg;
    assign ang     = atan_tab(i_reg);
    assign z_round = z_reg + 32'sd16384;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            COR_IDLE:
            begin
                if (start)
                    phase_next = (x_in == '0 && y_in == '0) ? COR_FIN : COR_NORM;
            end
            COR_NORM:
            begin
                if (!small1)
                    phase_next = COR_ROT;
            end
            COR_ROT:
            begin
                if (last_step)
                    phase_next = COR_FIN;
            end
            COR_FIN:
            begin
                phase_next = COR_IDLE;
            end
            default:
            begin
                phase_next = COR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= COR_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= phase_reg == COR_FIN;
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            COR_IDLE:
            begin
                x_reg <= {{2{x_in[31]}}, x_in};
                y_reg <= {{2{y_in[31]}}, y_in};
                z_reg <= '0;
                i_reg <= '0;
            end
            COR_NORM:
            begin
                if (small4)
                begin
                    x_reg <= x_reg <<< 4;
                    y_reg <= y_reg <<< 4;
                end
                else if (small1)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
                else if (x_reg < 0)
                begin
                    // quadrant pre-rotation into the right half plane
                    if (y_reg >= 0)
                    begin
                        x_reg <= y_reg;
                        y_reg <= -x_reg;
                        z_reg <= PI_HALF_Q28;
                    end
                    else
                    begin
                        x_reg <= -y_reg;
                        y_reg <= x_reg;
                        z_reg <= -PI_HALF_Q28;
                    end
                end
            end
            COR_ROT:
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + ang;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - ang;
                end
                i_reg <= i_reg + 1'b1;
            end
            default:
            begin
                angle_reg <= z_round[30:15];
            end
        endcase
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

FILE: hdl/three_joint_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// three_joint_arm_inverse_kinematics
// Base yaw plus two-link planar arm solver with held joint angles.
// ----------------------------------------------------------------------------
// From the accepting edge, a solve transfer runs through the sequencer states to the
// output register, plus the normalizing of the CORDIC inputs of small vectors;
// the four passes through the single shared CORDIC take most of that time, with
// two 16-step square roots and a 15-step divider behind them. A clear transfer
// goes straight to the done state, and a solve that stops on a zero link length
// goes there from the link check. The block takes one item at a time and is ready
// again as soon as the result is placed in the output register; while an
// earlier result still waits there, the block holds its result and stays busy.
module three_joint_arm_inverse_kinematics
    import tjik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic signed [15:0]   target_x,
    input  logic signed [15:0]   target_y,
    input  logic signed [15:0]   target_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   base_angle,
    output logic signed [15:0]   shoulder_angle,
    output logic signed [15:0]   elbow_angle,
    output logic [1:0]           status
);

    // configuration
    logic signed [15:0] height_reg;
    logic [14:0]        reach_reg;
    logic [14:0]        upper_reg;
    logic [14:0]        lower_reg;
    logic signed [15:0] shld_min_reg;
    logic signed [15:0] shld_max_reg;
    logic signed [15:0] elbw_min_reg;
    logic signed [15:0] elbw_max_reg;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic signed [15:0] tx_reg;
    logic signed [15:0] ty_reg;
    logic signed [16:0] pz_reg;
    logic signed [37:0] acc_reg;
    logic signed [17:0] axy_reg;
    logic [31:0]        den_reg;
    logic signed [15:0] c_reg;
    logic [14:0]        s_reg;
    logic signed [31:0] k1_reg;
    logic signed [31:0] k2_reg;
    logic signed [16:0] theta_reg;
    logic signed [15:0] q1_reg;
    logic signed [17:0] q3_reg;
    logic signed [15:0] held_base_reg;
    logic signed [15:0] held_shld_reg;
    logic signed [15:0] held_elbw_reg;
    logic [1:0]         status_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_base_reg;
    logic signed [15:0] out_shld_reg;
    logic signed [15:0] out_elbw_reg;
    logic [1:0]         out_status_reg;

    // shared unit hookup
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] prod;
    logic               sq_start;
    logic [31:0]        sq_op;
    logic               sq_done;
    logic [15:0]        sq_root;
    logic               div_start;
    logic               div_done;
    logic [14:0]        div_quot;
    logic               cor_start;
    logic signed [31:0] cor_y;
    logic signed [31:0] cor_x;
    logic               cor_done;
    logic signed [15:0] cor_angle;

    logic               in_xfer;
    logic               out_load;
    logic               links_zero;
    logic [37:0]        num_mag;
    logic               too_far;
    logic signed [17:0] q2;
    logic               in_limits;

    assign in_xfer    = in_valid && in_ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign links_zero = (upper_reg == '0) || (lower_reg == '0);
    assign num_mag    = acc_reg[37] ? 38'(-acc_reg) : 38'(acc_reg);
    assign too_far    = num_mag > {6'b0, den_reg};
    assign q2         = PI_HALF_Q13 - {theta_reg[16], theta_reg};
    assign in_limits  = (q2 > $signed({{2{shld_min_reg[15]}}, shld_min_reg}))
                     && (q2 < $signed({{2{shld_max_reg[15]}}, shld_max_reg}))
                     && (q3_reg > $signed({{2{elbw_min_reg[15]}}, elbw_min_reg}))
                     && (q3_reg < $signed({{2{elbw_max_reg[15]}}, elbw_max_reg}));

    tjik_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    tjik_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_op),
        .done    (sq_done),
        .root    (sq_root)
    );

    tjik_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_mag[31:0]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    tjik_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cor_done),
        .angle (cor_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg   <= -16'sd1120;
            reach_reg    <= 15'd1549;
            upper_reg    <= 15'd3200;
            lower_reg    <= 15'd3424;
            shld_min_reg <= -16'sd8192;
            shld_max_reg <= 16'sd6554;
            elbw_min_reg <= 16'sd0;
            elbw_max_reg <= 16'sd10650;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_HEIGHT:   height_reg   <= cfg_data;
                REG_REACH:    reach_reg    <= cfg_data[14:0];
                REG_UPPER:    upper_reg    <= cfg_data[14:0];
                REG_LOWER:    lower_reg    <= cfg_data[14:0];
                REG_SHLD_MIN: shld_min_reg <= cfg_data;
                REG_SHLD_MAX: shld_max_reg <= cfg_data;
                REG_ELBW_MIN: elbw_min_reg <= cfg_data;
                REG_ELBW_MAX: elbw_max_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = (opcode == OP_CLEAR) ? S_DONE : S_CHK;
            S_CHK:  state_next = links_zero ? S_DONE : S_MTY;
            S_MTY:  state_next = S_RSQ;
            S_RSQ:  state_next = S_RSQW;
            S_RSQW: if (sq_done) state_next = S_MAX;
            S_MAX:  state_next = S_MPZ;
            S_MPZ:  state_next = S_ML1;
            S_ML1:  state_next = S_ML2;
            S_ML2:  state_next = S_MLL;
            S_MLL:  state_next = S_DEN;
            S_DEN:  state_next = S_CMP;
            S_CMP:  state_next = too_far ? S_DONE : S_DIVW;
            S_DIVW: if (div_done) state_next = S_MCC;
            S_MCC:  state_next = S_SSQ;
            S_SSQ:  state_next = S_SSQW;
            S_SSQW: if (sq_done) state_next = S_MK1;
            S_MK1:  state_next = S_MK2;
            S_MK2:  state_next = S_MK3;
            S_MK3:  state_next = S_A1W;
            S_A1W:  if (cor_done) state_next = S_A2;
            S_A2:   state_next = S_A2W;
            S_A2W:  if (cor_done) state_next = S_A3;
            S_A3:   state_next = S_A3W;
            S_A3W:  if (cor_done) state_next = S_A4;
            S_A4:   state_next = S_A4W;
            S_A4W:  if (cor_done) state_next = S_LIM;
            S_LIM:  state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer: unit controls
    always_comb
    begin
        in_ready  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        sq_start  = 1'b0;
        sq_op     = acc_reg[31:0] + prod[31:0];
        div_start = 1'b0;
        cor_start = 1'b0;
        cor_y     = {{15{pz_reg[16]}}, pz_reg};
        cor_x     = {{14{axy_reg[17]}}, axy_reg};
        unique case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_CHK:
            begin
                mul_a = {{2{tx_reg[15]}}, tx_reg};
                mul_b = {{2{tx_reg[15]}}, tx_reg};
            end
            S_MTY:
            begin
                mul_a = {{2{ty_reg[15]}}, ty_reg};
                mul_b = {{2{ty_reg[15]}}, ty_reg};
            end
            S_RSQ: sq_start = 1'b1;
            S_MAX:
            begin
                mul_a = axy_reg;
                mul_b = axy_reg;
            end
            S_MPZ:
            begin
                mul_a = {pz_reg[16], pz_reg};
                mul_b = {pz_reg[16], pz_reg};
            end
            S_ML1:
            begin
                mul_a = {3'b000, upper_reg};
                mul_b = {3'b000, upper_reg};
            end
            S_ML2:
            begin
                mul_a = {3'b000, lower_reg};
                mul_b = {3'b000, lower_reg};
            end
            S_MLL:
            begin
                mul_a = {3'b000, upper_reg};
                mul_b = {3'b000, lower_reg};
            end
            S_CMP: div_start = !too_far;
            S_MCC:
            begin
                mul_a = {{2{c_reg[15]}}, c_reg};
                mul_b = {{2{c_reg[15]}}, c_reg};
            end
            S_SSQ:
            begin
                sq_start = 1'b1;
                sq_op    = ONE_SQ_Q28 - prod[31:0];
            end
            S_MK1:
            begin
                mul_a = {3'b000, lower_reg};
                mul_b = {{2{c_reg[15]}}, c_reg};
            end
            S_MK2:
            begin
                mul_a = {3'b000, lower_reg};
                mul_b = {3'b000, s_reg};
            end
            S_MK3: cor_start = 1'b1;
            S_A2:
            begin
                cor_start = 1'b1;
                cor_y     = k2_reg;
                cor_x     = k1_reg;
            end
            S_A3:
            begin
                cor_start = 1'b1;
                cor_y     = {{16{ty_reg[15]}}, ty_reg};
                cor_x     = {{16{tx_reg[15]}}, tx_reg};
            end
            S_A4:
            begin
                cor_start = 1'b1;
                cor_y     = {17'b0, s_reg};
                cor_x     = {{16{c_reg[15]}}, c_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_base_reg <= '0;
            held_shld_reg <= '0;
            held_elbw_reg <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_xfer)
            begin
                status_reg <= ST_OK;
                if (opcode == OP_CLEAR)
                begin
                    held_base_reg <= '0;
                    held_shld_reg <= '0;
                    held_elbw_reg <= '0;
                end
            end
            if (state_reg == S_CHK && links_zero)
                status_reg <= ST_UNREACH;
            if (state_reg == S_CMP && too_far)
                status_reg <= ST_UNREACH;
            if (state_reg == S_LIM)
            begin
                if (in_limits)
                begin
                    held_base_reg <= q1_reg;
                    held_shld_reg <= q2[15:0];
                    held_elbw_reg <= q3_reg[15:0];
                end
                else
                begin
                    status_reg <= ST_LIMIT;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                tx_reg <= target_x;
                ty_reg <= target_y;
                pz_reg <= {target_z[15], target_z} + {height_reg[15], height_reg};
            end
            S_MTY:  acc_reg <= {{2{prod[35]}}, prod};
            S_RSQW:
            begin
                if (sq_done)
                    axy_reg <= $signed({2'b00, sq_root}) - $signed({3'b000, reach_reg});
            end
            S_MPZ:  acc_reg <= {{2{prod[35]}}, prod};
            S_ML1:  acc_reg <= acc_reg + {{2{prod[35]}}, prod};
            S_ML2:  acc_reg <= acc_reg - {{2{prod[35]}}, prod};
            S_MLL:  acc_reg <= acc_reg - {{2{prod[35]}}, prod};
            S_DEN:  den_reg <= {prod[30:0], 1'b0};
            S_DIVW:
            begin
                // quotient truncates toward zero, sign follows the numerator
                if (div_done)
                    c_reg <= acc_reg[37] ? -$signed({1'b0, div_quot})
                                         : $signed({1'b0, div_quot});
            end
            S_SSQW:
            begin
                if (sq_done)
                    s_reg <= sq_root[14:0];
            end
            S_MK2:  k1_reg <= $signed({3'b000, upper_reg, 14'b0}) + prod[31:0];
            S_MK3:  k2_reg <= prod[31:0];
            S_A1W:
            begin
                if (cor_done)
                    theta_reg <= {cor_angle[15], cor_angle};
            end
            S_A2W:
            begin
                if (cor_done)
                    theta_reg <= theta_reg + {cor_angle[15], cor_angle};
            end
            S_A3W:
            begin
                if (cor_done)
                    q1_reg <= cor_angle;
            end
            S_A4W:
            begin
                if (cor_done)
                    q3_reg <= {{2{cor_angle[15]}}, cor_angle}
                            - {theta_reg[16], theta_reg};
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_base_reg   <= held_base_reg;
            out_shld_reg   <= held_shld_reg;
            out_elbw_reg   <= held_elbw_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign base_angle     = out_base_reg;
    assign shoulder_angle = out_shld_reg;
    assign elbow_angle    = out_elbw_reg;
    assign status         = out_status_reg;

endmodule

FILE: hdl/tjik_checker.sv
// ----------------------------------------------------------------------------
// tjik_checker
// Port-level checks of the arm solver, bound to the top level.
// ----------------------------------------------------------------------------
module tjik_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] base_angle,
    input logic signed [15:0] shoulder_angle,
    input logic signed [15:0] elbow_angle,
    input logic [1:0]         status
);

    // after an accepted item the block is not ready in the next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

    // the block stays ready while nothing arrives
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("ready dropped without a transfer");

    // a fresh result only comes out of a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(base_angle)
            && $stable(shoulder_angle) && $stable(elbow_angle) && $stable(status))
        else $error("stalled result changed");

endmodule

bind three_joint_arm_inverse_kinematics tjik_checker u_tjik_checker (.*);

FILE: bench/three_joint_arm_inverse_kinematics_checker.sv
// ----------------------------------------------------------------------------
// three_joint_arm_inverse_kinematics_checker
// Watches the configuration port and both channels of the arm solver, works
// out the expected joint angles and status for every accepted item and
// compares them, in order, with the results that leave the block.
// ----------------------------------------------------------------------------
module three_joint_arm_inverse_kinematics_checker
    import tjik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 opcode,
    input  logic signed [15:0]   target_x,
    input  logic signed [15:0]   target_y,
    input  logic signed [15:0]   target_z,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic signed [15:0]   base_angle,
    input  logic signed [15:0]   shoulder_angle,
    input  logic signed [15:0]   elbow_angle,
    input  logic [1:0]           status,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] base;
        logic signed [15:0] shoulder;
        logic signed [15:0] elbow;
        logic [1:0]         stat;
    } arm_pose_t;

    arm_pose_t          pose_queue[$];
    logic signed [15:0] held_base, held_shoulder, held_elbow;
    logic signed [15:0] height_off, shld_lo, shld_hi, elbw_lo, elbw_hi;
    logic [14:0]        reach_off, link_up, link_lo;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // vectoring cordic, angle in Q3.13
    function automatic longint arc_tangent(input longint y, input longint x);
        longint z, t, dx, dy;
        int     k;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        k = 0;
        while (k < 62 && abs64(x) < (64'sd1 <<< 30) && abs64(y) < (64'sd1 <<< 30))
        begin
            x = x * 2;
            y = y * 2;
            k++;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = PI_HALF_Q28;
            end
            else
            begin
                x = -y;
                y = t;
                z = -PI_HALF_Q28;
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_tab(5'(i)));
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_tab(5'(i)));
            end
        end
        return (z + (64'sd1 <<< 14)) >>> 15;
    endfunction

    function automatic arm_pose_t solve_pose(input logic op, input longint tx,
                                             input longint ty, input longint tz);
        arm_pose_t p;
        longint    pz, l1, l2, r, axy, d2, num, den, c, s, k1, k2, theta, q1, q2, q3;
        p.stat = ST_OK;
        if (op == OP_CLEAR)
        begin
            held_base = 0;
            held_shoulder = 0;
            held_elbow = 0;
        end
        else
        begin
            pz = tz + longint'(height_off);
            l1 = longint'(link_up);
            l2 = longint'(link_lo);
            if (l1 == 0 || l2 == 0)
                p.stat = ST_UNREACH;
            else
            begin
                r = longint'(int_sqrt(tx * tx + ty * ty));
                axy = r - longint'(reach_off);
                d2 = axy * axy + pz * pz;
                num = d2 - l1 * l1 - l2 * l2;
                den = 2 * l1 * l2;
                if (abs64(num) > den)
                    p.stat = ST_UNREACH;
                else
                begin
                    c = (num * 16384) / den;
                    s = longint'(int_sqrt((64'd1 << 28) - c * c));
                    k1 = l1 * 16384 + l2 * c;
                    k2 = l2 * s;
                    theta = arc_tangent(pz, axy) + arc_tangent(k2, k1);
                    q1 = arc_tangent(ty, tx);
                    q2 = PI_HALF_Q13 - theta;
                    q3 = arc_tangent(s, c) - theta;
                    if (!(q2 > shld_lo && q2 < shld_hi && q3 > elbw_lo && q3 < elbw_hi))
                        p.stat = ST_LIMIT;
                    else
                    begin
                        held_base = 16'(q1);
                        held_shoulder = 16'(q2);
                        held_elbow = 16'(q3);
                    end
                end
            end
        end
        p.base = held_base;
        p.shoulder = held_shoulder;
        p.elbow = held_elbow;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        arm_pose_t got, want;
        if (!rst_n)
        begin
            height_off <= -16'sd1120;
            reach_off  <= 15'd1549;
            link_up    <= 15'd3200;
            link_lo    <= 15'd3424;
            shld_lo    <= -16'sd8192;
            shld_hi    <= 16'sd6554;
            elbw_lo    <= 16'sd0;
            elbw_hi    <= 16'sd10650;
            held_base = 0;
            held_shoulder = 0;
            held_elbow = 0;
            pose_queue.delete();
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{base_angle, shoulder_angle, elbow_angle, status};
                if (pose_queue.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pose_queue.pop_front();
                    if (got != want)
                        fail_count <= fail_count + 1;
                    if (got.base != want.base)
                        $error("base_angle: expected %0d, got %0d", want.base, got.base);
                    if (got.shoulder != want.shoulder)
                        $error("shoulder_angle: expected %0d, got %0d",
                               want.shoulder, got.shoulder);
                    if (got.elbow != want.elbow)
                        $error("elbow_angle: expected %0d, got %0d", want.elbow, got.elbow);
                    if (got.stat != want.stat)
                        $error("status: expected %0d, got %0d", want.stat, got.stat);
                end
            end
            if (in_valid && in_ready)
                pose_queue.push_back(solve_pose(opcode, target_x, target_y, target_z));
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_HEIGHT:   height_off <= cfg_data;
                    REG_REACH:    reach_off  <= cfg_data[14:0];
                    REG_UPPER:    link_up    <= cfg_data[14:0];
                    REG_LOWER:    link_lo    <= cfg_data[14:0];
                    REG_SHLD_MIN: shld_lo    <= cfg_data;
                    REG_SHLD_MAX: shld_hi    <= cfg_data;
                    REG_ELBW_MIN: elbw_lo    <= cfg_data;
                    REG_ELBW_MAX: elbw_hi    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign pending_count = pose_queue.size();

endmodule

FILE: bench/three_joint_arm_inverse_kinematics_tb.sv
// ----------------------------------------------------------------------------
// three_joint_arm_inverse_kinematics_tb
// Drives directed and random solve and clear requests through the arm solver
// under several register settings and idle patterns, including a long output
// stall; the checker module judges every result.
// ----------------------------------------------------------------------------
module three_joint_arm_inverse_kinematics_tb;
    import tjik_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 in_valid, in_ready;
    logic                 opcode;
    logic signed [15:0]   target_x, target_y, target_z;
    logic                 out_valid, out_ready;
    logic signed [15:0]   base_angle, shoulder_angle, elbow_angle;
    logic [1:0]           status;
    int                   fail_count, pending_count;
    int                   send_idle_pct, recv_idle_pct;
    bit                   hold_output;
    int                   quiet_cycles;

    three_joint_arm_inverse_kinematics i_dut (.*);

    three_joint_arm_inverse_kinematics_checker i_checker (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_output)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("three_joint_arm_inverse_kinematics_tb: done, errors");
            $finish;
        end
    end

    // the block is busy the cycle after a transfer, so the gap costs nothing
    task automatic send_item(input logic op, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        opcode   <= op;
        target_x <= x;
        target_y <= y;
        target_z <= z;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_arm(input logic [15:0] h, input logic [15:0] r, input logic [15:0] l1,
                           input logic [15:0] l2, input logic [15:0] smin,
                           input logic [15:0] smax, input logic [15:0] emin,
                           input logic [15:0] emax);
        drain();
        write_reg(REG_HEIGHT, h);
        write_reg(REG_REACH, r);
        write_reg(REG_UPPER, l1);
        write_reg(REG_LOWER, l2);
        write_reg(REG_SHLD_MIN, smin);
        write_reg(REG_SHLD_MAX, smax);
        write_reg(REG_ELBW_MIN, emin);
        write_reg(REG_ELBW_MAX, emax);
    endtask

    // mostly reachable targets near the arm's workspace, some wild ones
    task automatic random_items(input int count, input int span);
        logic signed [15:0] x, y, z;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) < 7)
            begin
                x = 16'($urandom_range(2 * span) - span);
                y = 16'($urandom_range(2 * span) - span);
                z = 16'($urandom_range(2 * span) - span);
            end
            else
            begin
                x = 16'($urandom);
                y = 16'($urandom);
                z = 16'($urandom);
            end
            send_item($urandom_range(19) == 0 ? OP_CLEAR : OP_SOLVE, x, y, z);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_SOLVE;
        target_x = '0;
        target_y = '0;
        target_z = '0;
        send_idle_pct = 30;
        recv_idle_pct = 63;
        hold_output = 1'b0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both atan2 inputs zero, clears, limits
        send_item(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_SOLVE, 16'sd5000, 16'sd0, 16'sd1120);
        send_item(OP_SOLVE, 16'sd4000, 16'sd3000, 16'sd2000);
        send_item(OP_CLEAR, 16'h7fff, 16'h8000, 16'h5555);
        send_item(OP_SOLVE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(OP_SOLVE, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(OP_SOLVE, -16'sd4000, 16'sd3000, 16'sd500);
        send_item(OP_SOLVE, -16'sd4000, -16'sd3000, 16'sd500);
        send_item(OP_SOLVE, 16'sd0, -16'sd5000, 16'sd1500);
        send_item(OP_SOLVE, 16'sh2aaa, 16'sh5555, 16'shaaaa);
        // elbow fully stretched: cosine exactly one
        set_arm(16'sd0, 16'd0, 16'd100, 16'd100, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_item(OP_SOLVE, 16'sd200, 16'sd0, 16'sd0);
        send_item(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_SOLVE, 16'sd120, 16'sd50, 16'sd30);
        // zero link length and an ignored register index
        set_arm(16'sh7fff, 16'h7fff, 16'd0, 16'd3424, -16'sd8192, 16'sd6554, 16'sd0, 16'sd10650);
        write_reg(4'd12, 16'hffff);
        send_item(OP_SOLVE, 16'sd100, 16'sd100, 16'sd100);
        set_arm(16'sh8000, 16'd0, 16'd3200, 16'd0, -16'sd8192, 16'sd6554, 16'sd0, 16'sd10650);
        send_item(OP_SOLVE, 16'sd100, 16'sd100, 16'sd100);

        // random, first idle pattern, with a long output hold-off
        set_arm(-16'sd1120, 16'd1549, 16'd3200, 16'd3424, -16'sd8192, 16'sd6554,
                16'sd0, 16'sd10650);
        hold_output = 1'b1;
        fork
            random_items(10, 8000);
            begin
                repeat (1500) @(posedge clk);
                hold_output = 1'b0;
            end
        join
        random_items(350, 8000);

        // opposite idle pattern, small arm with wide limits
        send_idle_pct = 63;
        recv_idle_pct = 30;
        set_arm(16'sd0, 16'd0, 16'd300, 16'd250, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        random_items(350, 600);
        set_arm(16'sh7fff, 16'h7fff, 16'h7fff, 16'h7fff, -16'sd30000, 16'sd30000,
                -16'sd30000, 16'sd30000);
        random_items(150, 32767);

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_arm(16'sd500, 16'd800, 16'd1, 16'd2000, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff);
        random_items(100, 3000);
        set_arm(-16'sd1120, 16'd1549, 16'd3200, 16'd3424, -16'sd8192, 16'sd6554,
                16'sd0, 16'sd10650);
        random_items(550, 8000);

        drain();
        if (fail_count == 0)
            $display("three_joint_arm_inverse_kinematics_tb: done, clean");
        else
            $display("three_joint_arm_inverse_kinematics_tb: done, errors");
        $finish;
    end

endmodule
